>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a consequence holds in the cycle after its trigger.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pcfl_pkg.sv
// ----------------------------------------------------------------------------
// pcfl_pkg
// Shared codes and default sizes of the per-CPU page free-list allocator.
// ----------------------------------------------------------------------------
package pcfl_pkg;

  // Default sizes
  localparam int DEF_CPU_COUNT  = 8;
  localparam int DEF_PAGE_COUNT = 32768;
  localparam int DEF_PAGE_SIZE  = 4096;

  // Fixed field widths
  localparam int ADDR_W     = 32;
  localparam int CPU_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int FIRST_W    = 20;
  localparam int STOP_W     = 21;
  localparam int CFG_DATA_W = 21;
  localparam int CFG_IDX_W  = 1;

  // Operation kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_PAGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_PAGE  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [FIRST_W-1:0] FIRST_PAGE_RST = '0;
  localparam logic [STOP_W-1:0]  STOP_PAGE_RST  = 21'h100000;

endpackage

>>> rtl/per_cpu_page_free_list_alloc.sv
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_alloc
// A free or a failed allocate gives its item in the cycle after acceptance;
// an allocate that pops gives it from the S_POP state, once the link memory answers.
// Frees are taken one item per cycle while the receiver does not stall; no new
// request is taken while a popping allocate waits for its next-link memory read.
// Reset (rst, synchronous): every list empty, registers to defaults; the link
// memory needs no clearing pass, as only pushed pages are ever read back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module per_cpu_page_free_list_alloc
  import pcfl_pkg::*;
#(
  parameter int CPU_COUNT  = DEF_CPU_COUNT,
  parameter int PAGE_COUNT = DEF_PAGE_COUNT,
  parameter int PAGE_SIZE  = DEF_PAGE_SIZE
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic                  kind,
  input  logic [CPU_W-1:0]      cpu,
  input  logic [ADDR_W-1:0]     page_address,
  // response channel
  output logic                  resp_valid,
  input  logic                  resp_stall,
  output logic [ADDR_W-1:0]     alloc_address,
  output logic [STATUS_W-1:0]   status,
  output logic [CPU_W-1:0]      source_cpu
);

  // Page number width, CPU index width, byte offset width
  localparam int LW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int CW    = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int SHIFT = $clog2(PAGE_SIZE);

  // Sequencer states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic state;

  // Configuration registers
  logic [FIRST_W-1:0] first_page;
  logic [STOP_W-1:0]  stop_page;

  // List heads and their valid bits; a head is meaningful only while nonempty
  logic [LW-1:0]        head [CPU_COUNT];
  logic [CPU_COUNT-1:0] nonempty;

  // Link memory: {link valid, next page}, one entry per page
  logic [LW:0] link_mem [PAGE_COUNT];
  logic [LW:0] rd_data;

  // Pop in flight
  logic [CW-1:0] pop_from;
  logic [LW-1:0] pop_page;

  // Request decode
  logic          req_take;
  logic          resp_take;
  logic          resp_valid_next;
  logic          cpu_ok;
  logic [CW-1:0] cpu_idx;
  logic [31:0]   pg32;
  logic          free_bad;
  logic          own_ok;
  logic          any_ok;
  logic [CW-1:0] first_idx;
  logic [CW-1:0] from;
  logic [CW-1:0] hd_sel;
  logic [LW-1:0] hd_page;

  assign resp_take = resp_valid && !resp_stall;
  // Hold requests while a pop is in flight or the result slot stays full
  assign req_stall = (state != S_IDLE) || (resp_valid && resp_stall);
  assign req_take  = req_valid && !req_stall;

  assign cpu_ok  = 32'(cpu) < 32'(CPU_COUNT);
  assign cpu_idx = CW'(cpu);
  assign pg32    = page_address >> SHIFT;

  // A free is rejected on misalignment, out-of-window or out-of-store page, or unknown CPU
  assign free_bad = (page_address[SHIFT-1:0] != '0)
                 || (pg32 <  32'(first_page))
                 || (pg32 >= 32'(stop_page))
                 || (pg32 >= 32'(PAGE_COUNT))
                 || !cpu_ok;

  assign own_ok = cpu_ok && nonempty[cpu_idx];
  assign any_ok = |nonempty;

  // Lowest-numbered non-empty list; the own list is empty whenever this is used
  always_comb begin
    first_idx = '0;
    for (int c = CPU_COUNT - 1; c >= 0; c--) begin
      if (nonempty[c]) begin
        first_idx = CW'(c);
      end
    end
  end

  assign from    = own_ok ? cpu_idx : first_idx;
  // One head read per item: own list for a free, donor list for an allocate
  assign hd_sel  = (kind == KIND_FREE) ? cpu_idx : from;
  assign hd_page = head[hd_sel];

  // Raise the result when an item finishes, drop it once taken
  always_comb begin
    resp_valid_next = resp_valid && !resp_take;
    if (state == S_POP) begin
      resp_valid_next = 1'b1;
    end else if (req_take && (kind == KIND_FREE || !any_ok)) begin
      resp_valid_next = 1'b1;
    end
  end

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      first_page <= FIRST_PAGE_RST;
      stop_page  <= STOP_PAGE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FIRST_PAGE: first_page <= cfg_data[FIRST_W-1:0];
        REG_STOP_PAGE:  stop_page  <= cfg_data[STOP_W-1:0];
        default:        ;
      endcase
    end
  end

  // Link memory: push writes the old head behind the new page, pop reads it
  always_ff @(posedge clk) begin
    if (req_take && kind == KIND_FREE && !free_bad) begin
      link_mem[pg32[LW-1:0]] <= {nonempty[cpu_idx], hd_page};
    end
    if (req_take && kind == KIND_ALLOC) begin
      rd_data <= link_mem[hd_page];
    end
  end

  // Sequencer, list heads and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      nonempty   <= '0;
      resp_valid <= 1'b0;
    end else begin
      resp_valid <= resp_valid_next;
      case (state)
        S_IDLE: begin
          if (req_take) begin
            if (kind == KIND_FREE) begin
              // Push, or report the bad address with the state untouched
              alloc_address <= '0;
              source_cpu    <= '0;
              if (free_bad) begin
                status <= ST_BAD_FREE;
              end else begin
                status            <= ST_DONE;
                head[cpu_idx]     <= pg32[LW-1:0];
                nonempty[cpu_idx] <= 1'b1;
              end
            end else if (!any_ok) begin
              // Every list empty
              alloc_address <= '0;
              source_cpu    <= '0;
              status        <= ST_EMPTY;
            end else begin
              // Await the next link of the donor's head page
              pop_from <= from;
              pop_page <= hd_page;
              state    <= S_POP;
            end
          end
        end
        S_POP: begin
          // Advance the head, or drop the list when its last page goes
          if (rd_data[LW]) begin
            head[pop_from] <= rd_data[LW-1:0];
          end else begin
            nonempty[pop_from] <= 1'b0;
          end
          alloc_address <= ADDR_W'({{(ADDR_W - LW){1'b0}}, pop_page} << SHIFT);
          source_cpu    <= CPU_W'(pop_from);
          status        <= ST_DONE;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The result slot is always empty while a pop is in flight
  `ASSERT_ALWAYS(a_pop_slot_free, state != S_POP || !resp_valid,
                 "pop with result slot full")
  // A pop always ends in a successful result
  `ASSERT_NEXT(a_pop_result, state == S_POP,
               resp_valid && status == ST_DONE && state == S_IDLE,
               "pop gave no result")
  // A rejected free leaves the lists alone
  `ASSERT_NEXT(a_bad_free_stable, req_take && kind == KIND_FREE && free_bad,
               $stable(nonempty) && status == ST_BAD_FREE,
               "bad free changed lists")
  // An allocate with all lists empty reports empty at once
  `ASSERT_NEXT(a_empty_alloc, req_take && kind == KIND_ALLOC && nonempty == '0,
               resp_valid && status == ST_EMPTY && state == S_IDLE,
               "empty allocate mishandled")

endmodule

>>> bench/per_cpu_page_free_list_alloc_test.sv
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_alloc_test
// Self-checking bench for the per-CPU page free-list allocator. A mirror of
// the free lists predicts each response. Each response is then checked field
// by field against the oldest prediction. Directed frees and allocates cover
// page zero, bad addresses, stealing and an empty pool. Random phases follow.
// They vary the page window, the free/allocate mix, and the idling on both
// channels.
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_alloc_test
  import pcfl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CPU_COUNT   = DEF_CPU_COUNT;
  localparam int PAGE_COUNT  = DEF_PAGE_COUNT;
  localparam int PAGE_SIZE   = DEF_PAGE_SIZE;
  localparam int PG_W        = $clog2(PAGE_COUNT);
  localparam int CYCLE_LIMIT = 400000;

  // One response as the allocator should give it
  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [STATUS_W-1:0] status;
    logic [CPU_W-1:0]    src;
  } grant_t;

  // Mirror of the free lists: predicts every response and checks it.
  class free_list_mirror;
    logic [PG_W-1:0]    next_page [PAGE_COUNT];
    bit                 next_ok   [PAGE_COUNT];
    int unsigned        listed    [PAGE_COUNT];
    logic [PG_W-1:0]    head      [CPU_COUNT];
    bit                 busy      [CPU_COUNT];
    logic [FIRST_W-1:0] first_page;
    logic [STOP_W-1:0]  stop_page;
    grant_t             pending_grants [$];
    int                 errors;

    function new();
      foreach (next_ok[i]) begin
        next_page[i] = '0;
        next_ok[i]   = 1'b0;
        listed[i]    = 0;
      end
      foreach (busy[i]) begin
        head[i] = '0;
        busy[i] = 1'b0;
      end
      first_page = FIRST_PAGE_RST;
      stop_page  = STOP_PAGE_RST;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_FIRST_PAGE) begin
        first_page = data[FIRST_W-1:0];
      end else if (idx == REG_STOP_PAGE) begin
        stop_page = data[STOP_W-1:0];
      end
    endfunction

    function void fail(string msg);
      errors++;
      $display("%0t: %s", $time, msg);
    endfunction

    // Push or pop the mirror for one accepted request and queue its response
    function void note_request(logic k, logic [CPU_W-1:0] c, logic [ADDR_W-1:0] a);
      grant_t          g;
      int unsigned     pg;
      int              from;
      int              i;
      logic [PG_W-1:0] top;
      g = '0;
      if (k == KIND_FREE) begin
        pg = a / PAGE_SIZE;
        if ((a % PAGE_SIZE) != 0 || pg < first_page || pg >= stop_page ||
            pg >= PAGE_COUNT || c >= CPU_COUNT) begin
          g.status = ST_BAD_FREE;
        end else begin
          next_page[pg] = head[c];
          next_ok[pg]   = busy[c];
          head[c]       = pg[PG_W-1:0];
          busy[c]       = 1'b1;
          listed[pg]++;
        end
      end else begin
        from = -1;
        if (c < CPU_COUNT && busy[c]) begin
          from = c;
        end else begin
          for (i = 0; i < CPU_COUNT; i++) begin
            if (from < 0 && i != c && busy[i]) begin
              from = i;
            end
          end
        end
        if (from < 0) begin
          g.status = ST_EMPTY;
        end else begin
          top = head[from];
          if (next_ok[top]) begin
            head[from] = next_page[top];
          end else begin
            busy[from] = 1'b0;
          end
          if (listed[top] != 0) begin
            listed[top]--;
          end
          g.addr = ADDR_W'(int'(top) * PAGE_SIZE);
          g.src  = from[CPU_W-1:0];
        end
      end
      pending_grants.push_back(g);
    endfunction

    function void check_response(logic [ADDR_W-1:0] a, logic [STATUS_W-1:0] s,
                                 logic [CPU_W-1:0] src);
      grant_t g;
      if (pending_grants.size() == 0) begin
        fail($sformatf("unexpected response: alloc_address %h status %0d source_cpu %0d",
                       a, s, src));
        return;
      end
      g = pending_grants.pop_front();
      if (a !== g.addr) begin
        fail($sformatf("alloc_address expected %h actual %h", g.addr, a));
      end
      if (s !== g.status) begin
        fail($sformatf("status expected %0d actual %0d", g.status, s));
      end
      if (src !== g.src) begin
        fail($sformatf("source_cpu expected %0d actual %0d", g.src, src));
      end
    endfunction
  endclass

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = REG_FIRST_PAGE;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  req_valid    = 1'b0;
  logic                  req_stall;
  logic                  kind         = KIND_ALLOC;
  logic [CPU_W-1:0]      cpu          = '0;
  logic [ADDR_W-1:0]     page_address = '0;
  logic                  resp_valid;
  logic                  resp_stall   = 1'b0;
  logic [ADDR_W-1:0]     alloc_address;
  logic [STATUS_W-1:0]   status;
  logic [CPU_W-1:0]      source_cpu;

  free_list_mirror sb = new();

  // Idling in percent of cycles, set per phase
  int          gap_pct     = 0;
  int          stall_pct   = 0;
  int unsigned cycle_count = 0;

  per_cpu_page_free_list_alloc #(
    .CPU_COUNT  (CPU_COUNT),
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_SIZE  (PAGE_SIZE)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .kind          (kind),
    .cpu           (cpu),
    .page_address  (page_address),
    .resp_valid    (resp_valid),
    .resp_stall    (resp_stall),
    .alloc_address (alloc_address),
    .status        (status),
    .source_cpu    (source_cpu)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure: stall at random at the phase's rate
  always @(posedge clk) begin
    resp_stall <= ($urandom_range(99) < stall_pct);
  end

  // Check each accepted response; values seen here are the pre-edge ones
  always @(posedge clk) begin
    if (!rst && resp_valid && !resp_stall) begin
      sb.check_response(alloc_address, status, source_cpu);
    end
  end

  // Watchdog: give up well past the slowest correct run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one item, hold it while stalled, and note it in the mirror once taken.
  // The mirror is updated here so the next random choice sees the new lists.
  task automatic send_item(logic k, logic [CPU_W-1:0] c, logic [ADDR_W-1:0] a);
    while ($urandom_range(99) < gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid    <= 1'b1;
    kind         <= k;
    cpu          <= c;
    page_address <= a;
    @(posedge clk);
    while (req_stall !== 1'b0) begin
      @(posedge clk);
    end
    sb.note_request(k, c, a);
  endtask

  // Wait for the block to drain, then write both page limits back to back
  task automatic set_limits(logic [CFG_DATA_W-1:0] first, logic [CFG_DATA_W-1:0] stop);
    req_valid <= 1'b0;
    while (sb.pending_grants.size() != 0) begin
      @(posedge clk);
    end
    // let a popping allocate finish its link read
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_FIRST_PAGE;
    cfg_data  <= first;
    @(posedge clk);
    sb.write_reg(REG_FIRST_PAGE, first);
    cfg_index <= REG_STOP_PAGE;
    cfg_data  <= stop;
    @(posedge clk);
    sb.write_reg(REG_STOP_PAGE, stop);
    cfg_write <= 1'b0;
  endtask

  // Pick a legal page inside the window that no list holds yet, or -1.
  // Keeping such pages off the lists avoids loops that would never drain.
  function automatic int pick_page();
    int lo;
    int hi;
    int p;
    lo = sb.first_page;
    hi = (sb.stop_page < PAGE_COUNT) ? int'(sb.stop_page) : PAGE_COUNT;
    hi--;
    if (lo > hi) begin
      return -1;
    end
    repeat (8) begin
      p = ($urandom_range(9) == 0) ? ($urandom_range(1) ? lo : hi) : $urandom_range(hi, lo);
      if (sb.listed[p] == 0) begin
        return p;
      end
    end
    return -1;
  endfunction

  // Mostly well-formed frees and allocates; the rest are bad or odd frees
  task automatic random_item(int free_pct, int free_cpu_hi);
    logic [CPU_W-1:0]  c;
    logic [ADDR_W-1:0] a;
    int                p;
    int                r;
    int                donor;
    if ($urandom_range(99) >= free_pct) begin
      send_item(KIND_ALLOC, CPU_W'($urandom_range(CPU_COUNT - 1)), $urandom);
      return;
    end
    c     = CPU_W'($urandom_range(free_cpu_hi));
    r     = $urandom_range(99);
    p     = pick_page();
    donor = $urandom_range(CPU_COUNT - 1);
    if (r < 5 && !sb.busy[c] && sb.busy[donor]) begin
      // double free onto an empty list: it cuts the donor list short, no loop
      a = ADDR_W'(int'(sb.head[donor]) * PAGE_SIZE);
    end else if (r < 82 && p >= 0) begin
      a = ADDR_W'(p * PAGE_SIZE);
    end else if (r < 88 && p >= 0) begin
      a = ADDR_W'(p * PAGE_SIZE + $urandom_range(PAGE_SIZE - 1, 1));
    end else if (r < 94) begin
      // just outside the window, or past the end of the page store
      case ($urandom_range(2))
        0: a = ADDR_W'((longint'(sb.first_page) - 1) * PAGE_SIZE);
        1: begin
          if (longint'(sb.stop_page) * PAGE_SIZE < 64'h1_0000_0000) begin
            a = ADDR_W'(longint'(sb.stop_page) * PAGE_SIZE);
          end else begin
            a = ADDR_W'(longint'(PAGE_COUNT) * PAGE_SIZE);
          end
        end
        default: a = ADDR_W'(longint'($urandom_range(32'hFFFFF, PAGE_COUNT)) * PAGE_SIZE);
      endcase
    end else begin
      a = $urandom;
    end
    send_item(KIND_FREE, c, a);
  endtask

  task automatic run_phase(int items, int free_pct, int free_cpu_hi, int gap, int stall);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (items) random_item(free_pct, free_cpu_hi);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset window: whole address space
    send_item(KIND_ALLOC, 3'd3, $urandom);                        // nothing free anywhere
    send_item(KIND_FREE,  3'd0, 32'h0000_0000);                   // page zero
    send_item(KIND_FREE,  3'd7, 32'hFFFF_FFFF);                   // misaligned, all ones
    send_item(KIND_FREE,  3'd7, ADDR_W'((PAGE_COUNT - 1) * PAGE_SIZE));
    send_item(KIND_FREE,  3'd1, ADDR_W'(PAGE_COUNT * PAGE_SIZE)); // beyond the page store
    send_item(KIND_FREE,  3'd1, 32'h0000_1001);                   // misaligned
    send_item(KIND_FREE,  3'd2, ADDR_W'(5 * PAGE_SIZE));
    send_item(KIND_FREE,  3'd2, ADDR_W'(6 * PAGE_SIZE));
    send_item(KIND_FREE,  3'd2, ADDR_W'(7 * PAGE_SIZE));
    send_item(KIND_ALLOC, 3'd2, $urandom);                        // own list, last in first out
    send_item(KIND_ALLOC, 3'd2, $urandom);
    send_item(KIND_ALLOC, 3'd4, $urandom);                        // steal page zero from CPU 0
    send_item(KIND_ALLOC, 3'd0, $urandom);                        // steal from CPU 2
    send_item(KIND_ALLOC, 3'd1, $urandom);                        // steal the top page from CPU 7
    send_item(KIND_ALLOC, 3'd5, $urandom);                        // pool empty again
    send_item(KIND_FREE,  3'd3, ADDR_W'(9 * PAGE_SIZE));
    send_item(KIND_FREE,  3'd4, ADDR_W'(9 * PAGE_SIZE));          // double free, other CPU
    send_item(KIND_ALLOC, 3'd3, $urandom);
    send_item(KIND_ALLOC, 3'd4, $urandom);
    send_item(KIND_ALLOC, 3'd6, $urandom);

    // Narrow window: test both edges
    set_limits(21'd100, 21'd200);
    send_item(KIND_FREE, 3'd6, ADDR_W'(99 * PAGE_SIZE));          // below first page
    send_item(KIND_FREE, 3'd6, ADDR_W'(100 * PAGE_SIZE));
    send_item(KIND_FREE, 3'd5, ADDR_W'(199 * PAGE_SIZE));
    send_item(KIND_FREE, 3'd5, ADDR_W'(200 * PAGE_SIZE));         // at stop page

    // Random phases: window, free share, CPUs that free, sender gap, receiver stall
    set_limits(21'd0, 21'h100000);
    run_phase(300, 60, 7, 0, 0);
    set_limits(21'd100, 21'd5000);
    run_phase(250, 50, 2, 81, 0);
    run_phase(250, 35, 7, 0, 81);
    // first page register is only 20 bits wide; stop at zero rejects all
    set_limits(21'h1FFFFF, 21'd0);
    run_phase(100, 50, 7, 36, 36);
    set_limits(21'd0, 21'h100000);
    run_phase(300, 55, 7, 36, 36);
    set_limits(21'd32000, 21'd32768);
    run_phase(200, 50, 3, 0, 0);
    set_limits(21'd0, 21'd40000);
    run_phase(200, 45, 7, 81, 0);

    // Drain, then let a popping allocate finish before the verdict
    req_valid <= 1'b0;
    while (sb.pending_grants.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending_grants.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
